FILE: sv/voxocc_pkg.sv
package voxocc_pkg;

  // Grid geometry
  localparam int GRID_X     = 64;
  localparam int GRID_Y     = 64;
  localparam int GRID_Z     = 32;
  localparam int CELL_COUNT = GRID_X * GRID_Y * GRID_Z;
  localparam int IDX_W      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  // Field widths
  localparam int COORD_W    = 16;
  localparam int VAL_W      = 8;
  localparam int STEP_W     = 7;
  localparam int CALC_W     = 10;  // headroom for value +/- step or delta
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input function codes
  localparam logic [2:0] FUNC_HIT    = 3'd0;
  localparam logic [2:0] FUNC_MISS   = 3'd1;
  localparam logic [2:0] FUNC_MERGE  = 3'd2;
  localparam logic [2:0] FUNC_READ   = 3'd3;
  localparam logic [2:0] FUNC_CLEAR  = 3'd4;
  // Spare codes, served as a read
  localparam logic [2:0] FUNC_SPARE5 = 3'd5;
  localparam logic [2:0] FUNC_SPARE6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE7 = 3'd7;

  // Value conventions of the two modes
  localparam logic signed [CALC_W-1:0] MAX_M0  = 10'sd64;
  localparam logic signed [CALC_W-1:0] MIN_M0  = -10'sd63;
  localparam logic signed [CALC_W-1:0] EVEN_M0 = 10'sd0;
  localparam logic signed [CALC_W-1:0] UNK_M0  = 10'sd0;
  localparam logic signed [CALC_W-1:0] MAX_M1  = 10'sd127;
  localparam logic signed [CALC_W-1:0] MIN_M1  = 10'sd0;
  localparam logic signed [CALC_W-1:0] EVEN_M1 = 10'sd64;
  localparam logic signed [CALC_W-1:0] UNK_M1  = -10'sd1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_MODE    = 3'd0,
    CFG_HIT_STEP    = 3'd1,
    CFG_MISS_STEP   = 3'd2,
    CFG_ORIGIN_X    = 3'd3,
    CFG_ORIGIN_Y    = 3'd4,
    CFG_ORIGIN_Z    = 3'd5,
    CFG_OCC_THRESH  = 3'd6
  } cfg_idx_e;

  // Operation after classification by the front
  typedef enum logic [2:0] {
    OP_HIT,
    OP_MISS,
    OP_MERGE,
    OP_READ,
    OP_CLEAR,
    OP_OFF_MAP
  } op_e;

  typedef struct packed {
    logic                      map_mode;
    logic [STEP_W-1:0]         hit_step;
    logic [STEP_W-1:0]         miss_step;
    logic signed [COORD_W-1:0] corner_x;
    logic signed [COORD_W-1:0] corner_y;
    logic signed [COORD_W-1:0] corner_z;
    logic signed [VAL_W-1:0]   threshold;
  } cfg_t;

  typedef struct packed {
    op_e                     op;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] delta;
  } item_t;

  typedef struct packed {
    logic init_busy;  // clearing pass after reset in progress
  } back_status_t;

endpackage

FILE: sv/voxocc_if.sv
interface voxocc_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [2:0]                               func;
  logic signed [voxocc_pkg::COORD_W-1:0]    voxel_x;
  logic signed [voxocc_pkg::COORD_W-1:0]    voxel_y;
  logic signed [voxocc_pkg::COORD_W-1:0]    voxel_z;
  logic signed [voxocc_pkg::VAL_W-1:0]      merge_delta;

  modport source (output valid, func, voxel_x, voxel_y, voxel_z, merge_delta, input ready);
  modport sink   (input valid, func, voxel_x, voxel_y, voxel_z, merge_delta, output ready);
endinterface

interface voxocc_out_if;
  logic                                valid;
  logic                                ready;
  logic                                on_map;
  logic signed [voxocc_pkg::VAL_W-1:0] cell_value;
  logic                                occupied;
  logic                                is_unknown;

  modport source (output valid, on_map, cell_value, occupied, is_unknown, input ready);
  modport sink   (input valid, on_map, cell_value, occupied, is_unknown, output ready);
endinterface

FILE: sv/voxocc_front.sv
module voxocc_front (
  voxocc_in_if.sink                item_i,
  input  voxocc_pkg::cfg_t         cfg_i,
  input  voxocc_pkg::back_status_t status_i,
  output logic                     q_valid_o,
  input  logic                     q_ready_i,
  output voxocc_pkg::item_t        q_item_o
);

  logic signed [voxocc_pkg::COORD_W:0] dx, dy, dz;
  logic                                in_x, in_y, in_z, on_map;
  logic [31:0]                         idx_full;

  // Offsets from the grid origin, one bit wider so they cannot wrap
  always_comb begin
    dx = {item_i.voxel_x[voxocc_pkg::COORD_W-1], item_i.voxel_x}
       - {cfg_i.corner_x[voxocc_pkg::COORD_W-1], cfg_i.corner_x};
    dy = {item_i.voxel_y[voxocc_pkg::COORD_W-1], item_i.voxel_y}
       - {cfg_i.corner_y[voxocc_pkg::COORD_W-1], cfg_i.corner_y};
    dz = {item_i.voxel_z[voxocc_pkg::COORD_W-1], item_i.voxel_z}
       - {cfg_i.corner_z[voxocc_pkg::COORD_W-1], cfg_i.corner_z};
  end

  // Bounds check
  assign in_x   = !dx[voxocc_pkg::COORD_W] &&
                  (dx[voxocc_pkg::COORD_W-1:0] < voxocc_pkg::COORD_W'(voxocc_pkg::GRID_X));
  assign in_y   = !dy[voxocc_pkg::COORD_W] &&
                  (dy[voxocc_pkg::COORD_W-1:0] < voxocc_pkg::COORD_W'(voxocc_pkg::GRID_Y));
  assign in_z   = !dz[voxocc_pkg::COORD_W] &&
                  (dz[voxocc_pkg::COORD_W-1:0] < voxocc_pkg::COORD_W'(voxocc_pkg::GRID_Z));
  assign on_map = in_x && in_y && in_z;

  // Linear cell index, x major, z minor
  assign idx_full = (32'(dx[voxocc_pkg::COORD_W-1:0]) * 32'(voxocc_pkg::GRID_Y)
                   + 32'(dy[voxocc_pkg::COORD_W-1:0])) * 32'(voxocc_pkg::GRID_Z)
                   + 32'(dz[voxocc_pkg::COORD_W-1:0]);

  // Classification
  always_comb begin
    q_item_o.idx   = idx_full[voxocc_pkg::IDX_W-1:0];
    q_item_o.delta = item_i.merge_delta;
    if (item_i.func == voxocc_pkg::FUNC_CLEAR) begin
      q_item_o.op = voxocc_pkg::OP_CLEAR;
    end else if (!on_map) begin
      q_item_o.op = voxocc_pkg::OP_OFF_MAP;
    end else begin
      case (item_i.func)
        voxocc_pkg::FUNC_HIT:   q_item_o.op = voxocc_pkg::OP_HIT;
        voxocc_pkg::FUNC_MISS:  q_item_o.op = voxocc_pkg::OP_MISS;
        voxocc_pkg::FUNC_MERGE: begin
          q_item_o.op = (item_i.merge_delta == '0) ? voxocc_pkg::OP_READ
                                                   : voxocc_pkg::OP_MERGE;
        end
        default:                q_item_o.op = voxocc_pkg::OP_READ;
      endcase
    end
  end

  // No transaction taken while the store is being initialised
  assign q_valid_o    = item_i.valid && !status_i.init_busy;
  assign item_i.ready = q_ready_i && !status_i.init_busy;

endmodule

FILE: sv/voxocc_fifo.sv
module voxocc_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  voxocc_pkg::item_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output voxocc_pkg::item_t out_item_o
);

  voxocc_pkg::item_t                entry_q [voxocc_pkg::QUEUE_DEPTH];
  logic [voxocc_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [voxocc_pkg::QCNT_W-1:0]    cnt_q;
  logic                             push, pop;

  assign in_ready_o  = cnt_q != voxocc_pkg::QCNT_W'(voxocc_pkg::QUEUE_DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign out_item_o  = entry_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= in_item_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == voxocc_pkg::QPTR_W'(voxocc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == voxocc_pkg::QPTR_W'(voxocc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: sv/voxocc_back.sv
module voxocc_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  voxocc_pkg::cfg_t         cfg_i,
  input  logic                     q_valid_i,
  output logic                     q_ready_o,
  input  voxocc_pkg::item_t        q_item_i,
  voxocc_out_if.source             result_o,
  output voxocc_pkg::back_status_t status_o
);

  typedef enum logic [1:0] {
    S_INIT,
    S_CLEAR,
    S_IDLE,
    S_UPDATE
  } state_e;

  state_e                              state_q;
  logic [voxocc_pkg::IDX_W-1:0]        sweep_q;
  logic [voxocc_pkg::VAL_W-1:0]        fill_q;
  voxocc_pkg::op_e                     op_q;
  logic [voxocc_pkg::IDX_W-1:0]        addr_q;
  logic signed [voxocc_pkg::VAL_W-1:0] delta_q;

  logic                                out_valid_q;
  logic                                out_valid_d;
  logic                                out_load;
  logic                                out_on_map_q;
  logic signed [voxocc_pkg::VAL_W-1:0] out_value_q;
  logic                                out_occ_q;
  logic                                out_unk_q;

  logic [voxocc_pkg::VAL_W-1:0]        mem_q [voxocc_pkg::CELL_COUNT];
  logic signed [voxocc_pkg::VAL_W-1:0] rd_q;
  logic                                mem_we;
  logic [voxocc_pkg::IDX_W-1:0]        mem_waddr;
  logic [voxocc_pkg::VAL_W-1:0]        mem_wdata;

  logic signed [voxocc_pkg::CALC_W-1:0] mx, mn, ev, un;
  logic signed [voxocc_pkg::CALC_W-1:0] val, hit_ext, miss_ext, delta_ext, base, sum, nv;
  logic signed [voxocc_pkg::VAL_W-1:0]  new_val, unk_val;
  logic                                 out_free, sweep_last;

  // Value convention of the current mode
  always_comb begin
    mx = cfg_i.map_mode ? voxocc_pkg::MAX_M1  : voxocc_pkg::MAX_M0;
    mn = cfg_i.map_mode ? voxocc_pkg::MIN_M1  : voxocc_pkg::MIN_M0;
    ev = cfg_i.map_mode ? voxocc_pkg::EVEN_M1 : voxocc_pkg::EVEN_M0;
    un = cfg_i.map_mode ? voxocc_pkg::UNK_M1  : voxocc_pkg::UNK_M0;
  end
  assign unk_val = un[voxocc_pkg::VAL_W-1:0];

  // Saturating update of the cell just read
  always_comb begin
    val       = {{(voxocc_pkg::CALC_W - voxocc_pkg::VAL_W){rd_q[voxocc_pkg::VAL_W-1]}}, rd_q};
    hit_ext   = {{(voxocc_pkg::CALC_W - voxocc_pkg::STEP_W){1'b0}}, cfg_i.hit_step};
    miss_ext  = {{(voxocc_pkg::CALC_W - voxocc_pkg::STEP_W){1'b0}}, cfg_i.miss_step};
    delta_ext = {{(voxocc_pkg::CALC_W - voxocc_pkg::VAL_W){delta_q[voxocc_pkg::VAL_W-1]}},
                 delta_q};
    base      = (val == un) ? ev : val;
    sum       = '0;
    nv        = val;
    case (op_q)
      voxocc_pkg::OP_HIT: begin
        sum = base + hit_ext;
        if (val == un) begin
          nv = (sum > mx) ? mx : sum;
        end else begin
          nv = (sum < mx) ? sum : mx;
        end
      end
      voxocc_pkg::OP_MISS: begin
        sum = base - miss_ext;
        if (val == un) begin
          nv = (sum < mn) ? mn : sum;
        end else begin
          nv = (sum > mn) ? sum : mn;
        end
      end
      voxocc_pkg::OP_MERGE: begin
        sum = base + delta_ext;
        if (sum > mx) begin
          nv = mx;
        end else if (sum < mn) begin
          nv = mn;
        end else begin
          nv = sum;
        end
      end
      default: nv = val;
    endcase
    new_val = nv[voxocc_pkg::VAL_W-1:0];
  end

  // Cell store: one write port, one registered read port
  assign mem_we    = (state_q == S_INIT) || (state_q == S_CLEAR) || (state_q == S_UPDATE);
  assign mem_waddr = (state_q == S_UPDATE) ? addr_q : sweep_q;
  assign mem_wdata = (state_q == S_UPDATE) ? new_val : fill_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[q_item_i.idx];
  end

  assign out_free   = !out_valid_q || result_o.ready;
  assign q_ready_o  = (state_q == S_IDLE) && out_free;
  assign sweep_last = sweep_q == voxocc_pkg::IDX_W'(voxocc_pkg::CELL_COUNT - 1);

  // Result register loads on a clear or off-grid pop and at the end of an update
  assign out_load    = (state_q == S_UPDATE) ||
                       ((state_q == S_IDLE) && q_valid_i && out_free &&
                        ((q_item_i.op == voxocc_pkg::OP_CLEAR) ||
                         (q_item_i.op == voxocc_pkg::OP_OFF_MAP)));
  assign out_valid_d = out_load || (out_valid_q && !result_o.ready);

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      sweep_q      <= '0;
      fill_q       <= voxocc_pkg::UNK_M0[voxocc_pkg::VAL_W-1:0];
      op_q         <= voxocc_pkg::OP_READ;
      addr_q       <= '0;
      delta_q      <= '0;
      out_valid_q  <= 1'b0;
      out_on_map_q <= 1'b0;
      out_value_q  <= '0;
      out_occ_q    <= 1'b0;
      out_unk_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        S_INIT, S_CLEAR: begin
          sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
          if (sweep_last) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid_i && out_free) begin
            op_q    <= q_item_i.op;
            addr_q  <= q_item_i.idx;
            delta_q <= q_item_i.delta;
            case (q_item_i.op)
              voxocc_pkg::OP_CLEAR: begin
                // result goes out now, the sweep follows
                fill_q       <= unk_val;
                sweep_q      <= '0;
                state_q      <= S_CLEAR;
                out_on_map_q <= 1'b0;
                out_value_q  <= unk_val;
                out_occ_q    <= unk_val >= cfg_i.threshold;
                out_unk_q    <= 1'b1;
              end
              voxocc_pkg::OP_OFF_MAP: begin
                out_on_map_q <= 1'b0;
                out_value_q  <= '0;
                out_occ_q    <= 1'b0;
                out_unk_q    <= 1'b0;
              end
              default: state_q <= S_UPDATE;
            endcase
          end
        end
        S_UPDATE: begin
          state_q      <= S_IDLE;
          out_on_map_q <= 1'b1;
          out_value_q  <= new_val;
          out_occ_q    <= new_val >= cfg_i.threshold;
          out_unk_q    <= new_val == unk_val;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.on_map     = out_on_map_q;
  assign result_o.cell_value = out_value_q;
  assign result_o.occupied   = out_occ_q;
  assign result_o.is_unknown = out_unk_q;

  assign status_o.init_busy  = state_q == S_INIT;

endmodule

FILE: sv/voxel_occupancy_update.sv
// Occupancy grid of 64 x 64 x 32 signed 8-bit cells held in a single-port-write,
// registered-read memory. A front stage bounds-checks each transaction against the
// configured origin and classifies it; a two-entry queue feeds the back stage,
// which owns the memory. An on-grid hit, miss, merge or read is served in the
// back stage by a memory read, then update and write-back; an off-grid transaction
// loads its result at the pop; a clear returns its result at once and then sweeps
// all 131072 cells of the store at one cell per cycle before the next transaction
// is served. After reset the same clearing pass runs and no transaction is
// accepted until it ends; configuration writes are taken throughout.
module voxel_occupancy_update (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  voxocc_in_if.sink                           item_i,
  voxocc_out_if.source                        result_o,
  input  logic                                cfg_we_i,
  input  logic [voxocc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [voxocc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  voxocc_pkg::cfg_t         cfg_q;
  voxocc_pkg::back_status_t status;
  voxocc_pkg::item_t        fq_in_item, fq_out_item;
  logic                     fq_in_valid, fq_in_ready, fq_out_valid, fq_out_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_mode  <= 1'b0;
      cfg_q.hit_step  <= voxocc_pkg::STEP_W'(1);
      cfg_q.miss_step <= voxocc_pkg::STEP_W'(1);
      cfg_q.corner_x  <= '0;
      cfg_q.corner_y  <= '0;
      cfg_q.corner_z  <= '0;
      cfg_q.threshold <= voxocc_pkg::VAL_W'(50);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        voxocc_pkg::CFG_MAP_MODE:   cfg_q.map_mode  <= cfg_data_i[0];
        voxocc_pkg::CFG_HIT_STEP:   cfg_q.hit_step  <= cfg_data_i[voxocc_pkg::STEP_W-1:0];
        voxocc_pkg::CFG_MISS_STEP:  cfg_q.miss_step <= cfg_data_i[voxocc_pkg::STEP_W-1:0];
        voxocc_pkg::CFG_ORIGIN_X:   cfg_q.corner_x  <= cfg_data_i[voxocc_pkg::COORD_W-1:0];
        voxocc_pkg::CFG_ORIGIN_Y:   cfg_q.corner_y  <= cfg_data_i[voxocc_pkg::COORD_W-1:0];
        voxocc_pkg::CFG_ORIGIN_Z:   cfg_q.corner_z  <= cfg_data_i[voxocc_pkg::COORD_W-1:0];
        voxocc_pkg::CFG_OCC_THRESH: cfg_q.threshold <= cfg_data_i[voxocc_pkg::VAL_W-1:0];
        default: ;
      endcase
    end
  end

  voxocc_front u_front (
    .item_i    (item_i),
    .cfg_i     (cfg_q),
    .status_i  (status),
    .q_valid_o (fq_in_valid),
    .q_ready_i (fq_in_ready),
    .q_item_o  (fq_in_item)
  );

  voxocc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fq_in_valid),
    .in_ready_o  (fq_in_ready),
    .in_item_i   (fq_in_item),
    .out_valid_o (fq_out_valid),
    .out_ready_i (fq_out_ready),
    .out_item_o  (fq_out_item)
  );

  voxocc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (fq_out_valid),
    .q_ready_o (fq_out_ready),
    .q_item_i  (fq_out_item),
    .result_o  (result_o),
    .status_o  (status)
  );

  // No result can be pending while the store is still being initialised
  a_no_result_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.init_busy |-> !result_o.valid)
    else $error("result pending during initial clearing pass");

  // The back stage only takes a queued transaction when the result register is free
  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fq_out_valid && fq_out_ready) |-> (!result_o.valid || result_o.ready))
    else $error("queue popped while result register blocked");

  // Off-grid results carry zeros; only a clear reports unknown off the grid
  a_off_map_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.on_map && !result_o.is_unknown) |->
      (result_o.cell_value == '0 && !result_o.occupied))
    else $error("off-grid result with non-zero payload");

endmodule

FILE: verif/occupancy_checker.sv
// Watches the item and result channels and the register port, keeps its own copy
// of the grid and the register settings, and checks each result in order.
module occupancy_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  voxocc_in_if                                item_mon_i,
  voxocc_out_if                               result_mon_i,
  input  logic                                cfg_we_i,
  input  logic [voxocc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [voxocc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  checked_o,
  output int                                  on_grid_o,
  output int                                  clears_o
);

  import voxocc_pkg::*;

  typedef struct packed {
    logic             on_map;
    logic [VAL_W-1:0] cell_value;
    logic             occupied;
    logic             is_unknown;
  } grid_result_t;

  // Shadow register settings
  logic                      mode;
  logic [STEP_W-1:0]         hit_step;
  logic [STEP_W-1:0]         miss_step;
  logic signed [COORD_W-1:0] org_x;
  logic signed [COORD_W-1:0] org_y;
  logic signed [COORD_W-1:0] org_z;
  logic signed [VAL_W-1:0]   thresh;

  // Shadow grid and the results still owed by the block
  logic signed [VAL_W-1:0]   cells [CELL_COUNT];
  grid_result_t              owed_q[$];
  grid_result_t              want;

  function automatic void sweep_cells(logic signed [VAL_W-1:0] fill);
    for (int c = 0; c < CELL_COUNT; c++) cells[c] = fill;
  endfunction

  // Apply one transaction to the shadow grid and return the result it should give
  function automatic grid_result_t apply_update(logic [2:0] fn,
                                                logic signed [COORD_W-1:0] vx,
                                                logic signed [COORD_W-1:0] vy,
                                                logic signed [COORD_W-1:0] vz,
                                                logic signed [VAL_W-1:0] dlt);
    int top_v, bot_v, even_v, unk_v, dx, dy, dz, v, cidx;
    grid_result_t r;
    top_v  = mode ? 127 : 64;
    bot_v  = mode ? 0 : -63;
    even_v = mode ? 64 : 0;
    unk_v  = mode ? -1 : 0;
    dx = int'(vx) - int'(org_x);
    dy = int'(vy) - int'(org_y);
    dz = int'(vz) - int'(org_z);
    r  = '0;
    if (fn == FUNC_CLEAR) begin
      // coordinate ignored, every cell back to unknown
      sweep_cells(unk_v[VAL_W-1:0]);
      r.cell_value = unk_v[VAL_W-1:0];
      r.occupied   = (unk_v >= int'(thresh));
      r.is_unknown = 1'b1;
    end else if (dx >= 0 && dx < GRID_X && dy >= 0 && dy < GRID_Y &&
                 dz >= 0 && dz < GRID_Z) begin
      cidx = (dx * GRID_Y + dy) * GRID_Z + dz;
      v    = int'(cells[cidx]);
      case (fn)
        FUNC_HIT: begin
          if (v == unk_v) begin
            v = even_v + int'(hit_step);
            if (v > top_v) v = top_v;
          end else if (v + int'(hit_step) < top_v) begin
            v = v + int'(hit_step);
          end else begin
            v = top_v;
          end
        end
        FUNC_MISS: begin
          if (v == unk_v) begin
            v = even_v - int'(miss_step);
            if (v < bot_v) v = bot_v;
          end else if (v - int'(miss_step) > bot_v) begin
            v = v - int'(miss_step);
          end else begin
            v = bot_v;
          end
        end
        FUNC_MERGE: begin
          // zero delta leaves the cell alone, unknown included
          if (dlt != 0) begin
            if (v == unk_v) v = even_v;
            v = v + int'(dlt);
            if (v > top_v) v = top_v;
            else if (v < bot_v) v = bot_v;
          end
        end
        default: ;  // read and the spare codes
      endcase
      cells[cidx]  = v[VAL_W-1:0];
      r.on_map     = 1'b1;
      r.cell_value = v[VAL_W-1:0];
      r.occupied   = (v >= int'(thresh));
      r.is_unknown = (v == unk_v);
    end
    return r;
  endfunction

  task automatic compare_field(string name, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode      = 1'b0;
      hit_step  = 7'd1;
      miss_step = 7'd1;
      org_x     = '0;
      org_y     = '0;
      org_z     = '0;
      thresh    = 8'sd50;
      sweep_cells('0);
      owed_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      on_grid_o    = 0;
      clears_o     = 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MAP_MODE:   mode      = cfg_data_i[0];
          CFG_HIT_STEP:   hit_step  = cfg_data_i[STEP_W-1:0];
          CFG_MISS_STEP:  miss_step = cfg_data_i[STEP_W-1:0];
          CFG_ORIGIN_X:   org_x     = cfg_data_i[COORD_W-1:0];
          CFG_ORIGIN_Y:   org_y     = cfg_data_i[COORD_W-1:0];
          CFG_ORIGIN_Z:   org_z     = cfg_data_i[COORD_W-1:0];
          CFG_OCC_THRESH: thresh    = cfg_data_i[VAL_W-1:0];
          default: ;
        endcase
      end
      // item transaction: predict first, so a same-edge result still finds it
      if (item_mon_i.valid && item_mon_i.ready) begin
        if (item_mon_i.func == FUNC_CLEAR) clears_o++;
        owed_q.insert(owed_q.size(), apply_update(item_mon_i.func, item_mon_i.voxel_x,
                                                  item_mon_i.voxel_y, item_mon_i.voxel_z,
                                                  item_mon_i.merge_delta));
      end
      // result transaction
      if (result_mon_i.valid && result_mon_i.ready) begin
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got cell_value %0h on_map %0b",
                   $time, result_mon_i.cell_value, result_mon_i.on_map);
          fail_count_o++;
        end else begin
          want = owed_q.pop_front();
          checked_o++;
          if (want.on_map) on_grid_o++;
          compare_field("on_map", want.on_map, result_mon_i.on_map);
          compare_field("cell_value", want.cell_value, result_mon_i.cell_value);
          compare_field("occupied", want.occupied, result_mon_i.occupied);
          compare_field("is_unknown", want.is_unknown, result_mon_i.is_unknown);
        end
      end
      pending_o = owed_q.size();
    end
  end

endmodule

FILE: verif/tb.sv
module tb;

  import voxocc_pkg::*;

  // A clear or the post-reset pass holds the block for one cell per cycle;
  // allow several of those with nothing moving before giving up.
  localparam int STALL_LIMIT   = 600000;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 100;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  calm;

  int org_x, org_y, org_z;
  int hot_x[8], hot_y[8], hot_z[8];
  int clears_left;
  int settings_used;

  int fail_count, pending, n_checked, n_on_grid, n_clears;

  voxocc_in_if  item_if();
  voxocc_out_if result_if();

  voxel_occupancy_update u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_if),
    .result_o    (result_if),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  occupancy_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_mon_i   (item_if),
    .result_mon_i (result_if),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (n_checked),
    .on_grid_o    (n_on_grid),
    .clears_o     (n_clears)
  );

  always #10 clk_i = ~clk_i;

  // Result side stalls at random except during the calm stretch
  always @(negedge clk_i) begin
    result_if.ready <= calm || ($urandom_range(99) >= 23);
  end

  // Entered at a falling edge; leaves the write enable high for a following write
  task automatic write_reg(cfg_idx_e idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(negedge clk_i);
  endtask

  task automatic set_map(int mode, int hit, int miss, int ox, int oy, int oz, int thr);
    write_reg(CFG_MAP_MODE, mode);
    write_reg(CFG_HIT_STEP, hit);
    write_reg(CFG_MISS_STEP, miss);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_OCC_THRESH, thr);
    cfg_we <= 1'b0;
    org_x = ox;
    org_y = oy;
    org_z = oz;
    settings_used++;
  endtask

  // Present one item and hold it until the block takes it
  task automatic send_item(logic [2:0] fn, int x, int y, int z, int dlt);
    while (!calm && $urandom_range(99) < 23) begin
      item_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_if.valid       <= 1'b1;
    item_if.func        <= fn;
    item_if.voxel_x     <= x[COORD_W-1:0];
    item_if.voxel_y     <= y[COORD_W-1:0];
    item_if.voxel_z     <= z[COORD_W-1:0];
    item_if.merge_delta <= dlt[VAL_W-1:0];
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Coordinates given relative to the current grid origin
  task automatic send_rel(logic [2:0] fn, int dx, int dy, int dz, int dlt);
    send_item(fn, org_x + dx, org_y + dy, org_z + dz, dlt);
  endtask

  task automatic drain();
    item_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Idle point for register writes: a read can only be served once any sweep is over
  task automatic settle();
    drain();
    send_rel(FUNC_READ, 0, 0, 0, 0);
    drain();
    repeat (8) @(negedge clk_i);
  endtask

  function automatic int pick_step();
    case ($urandom_range(5))
      0:       return 0;
      1:       return 127;
      2:       return 1;
      default: return $urandom_range(2, 40);
    endcase
  endfunction

  function automatic int pick_origin(int span);
    case ($urandom_range(5))
      0:       return -32768;
      1:       return 32767 - span + 1;
      2:       return 32767;
      default: return $urandom_range(65535 - span + 1) - 32768;
    endcase
  endfunction

  function automatic int pick_thresh();
    case ($urandom_range(4))
      0:       return -128;
      1:       return 127;
      2:       return $urandom_range(255) - 128;
      default: return $urandom_range(127) - 63;
    endcase
  endfunction

  task automatic new_hot_cells();
    for (int i = 0; i < 8; i++) begin
      hot_x[i] = $urandom_range(GRID_X - 1);
      hot_y[i] = $urandom_range(GRID_Y - 1);
      hot_z[i] = $urandom_range(GRID_Z - 1);
    end
    // two grid corners always in the pool
    hot_x[0] = 0;
    hot_y[0] = 0;
    hot_z[0] = 0;
    hot_x[1] = GRID_X - 1;
    hot_y[1] = GRID_Y - 1;
    hot_z[1] = GRID_Z - 1;
  endtask

  // Mostly repeated updates of a few cells so they saturate, plus edges and noise
  task automatic random_item();
    int kind, h, fn, x, y, z, dlt;
    kind = $urandom_range(99);
    h    = $urandom_range(7);
    fn   = $urandom_range(3);
    dlt  = ($urandom_range(9) == 0) ? 0 : $urandom_range(255) - 128;
    x    = org_x + hot_x[h];
    y    = org_y + hot_y[h];
    z    = org_z + hot_z[h];
    if (kind < 15) begin
      x = org_x + $urandom_range(GRID_X - 1);
      y = org_y + $urandom_range(GRID_Y - 1);
      z = org_z + $urandom_range(GRID_Z - 1);
    end else if (kind < 25) begin
      // one axis just past the grid
      case ($urandom_range(5))
        0:       x = org_x - 1;
        1:       x = org_x + GRID_X;
        2:       y = org_y - 1;
        3:       y = org_y + GRID_Y;
        4:       z = org_z - 1;
        default: z = org_z + GRID_Z;
      endcase
    end else if (kind < 30) begin
      x  = $urandom_range(65535);
      y  = $urandom_range(65535);
      z  = $urandom_range(65535);
      fn = $urandom_range(7);
    end
    if (fn == FUNC_CLEAR) fn = FUNC_READ;
    // full clears are costly, so only a couple
    if (clears_left > 0 && $urandom_range(299) == 0) begin
      fn = FUNC_CLEAR;
      clears_left--;
    end
    send_item(fn[2:0], x, y, z, dlt);
  endtask

  // No transaction on either channel for too long ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    calm                = 1'b0;
    item_if.valid       = 1'b0;
    item_if.func        = '0;
    item_if.voxel_x     = '0;
    item_if.voxel_y     = '0;
    item_if.voxel_z     = '0;
    item_if.merge_delta = '0;
    org_x               = 0;
    org_y               = 0;
    org_z               = 0;
    clears_left         = 2;
    settings_used       = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Mode 0, lowest x origin, grid ending at the top of z; writes land during
    // the post-reset pass and leave the mode as it was
    set_map(0, 3, 127, -32768, -100, 32736, 64);
    send_rel(FUNC_READ, 0, 0, 0, 0);       // untouched cell reads unknown
    send_rel(FUNC_HIT, 0, 0, 0, 0);        // unknown starts from even
    send_rel(FUNC_HIT, 0, 0, 0, 0);
    send_rel(FUNC_MISS, 0, 0, 0, 0);       // saturates at the floor
    send_rel(FUNC_MERGE, 0, 0, 0, 0);      // zero delta skipped
    send_rel(FUNC_MERGE, 0, 0, 0, 127);    // clamps at the top
    send_rel(FUNC_MERGE, 0, 0, 0, -128);   // clamps at the floor
    send_rel(FUNC_SPARE5, 0, 0, 0, 0);     // spare codes act as read
    send_rel(FUNC_SPARE6, 63, 63, 31, 0);
    send_rel(FUNC_SPARE7, 63, 63, 31, -1);
    send_rel(FUNC_HIT, 63, 63, 31, 0);     // far corner, z = 32767
    send_rel(FUNC_READ, 64, 0, 0, 0);      // just past each axis
    send_rel(FUNC_MISS, 0, 0, -1, 0);
    send_rel(FUNC_MERGE, 0, 64, 0, 5);
    send_item(FUNC_READ, 32767, -32768, 0, 0);
    send_item(FUNC_CLEAR, -1, -1, -1, -1); // coordinate ignored
    settle();

    // Mode 1, x grid ending at 32767, z at the bottom, zero miss step
    set_map(1, 127, 0, 32704, 0, -32768, -128);
    send_rel(FUNC_READ, 63, 0, 0, 0);      // mode-0 unknown is a plain value here
    send_rel(FUNC_MISS, 63, 0, 0, 0);
    send_rel(FUNC_HIT, 63, 0, 0, 0);
    send_rel(FUNC_CLEAR, 0, 0, 0, 0);
    send_rel(FUNC_READ, 63, 0, 0, 0);
    send_rel(FUNC_MISS, 63, 0, 0, 0);
    send_rel(FUNC_HIT, 5, 5, 5, 0);
    send_rel(FUNC_MERGE, 6, 6, 6, -1);     // unknown to even before the add
    send_rel(FUNC_MERGE, 7, 7, 7, 0);      // unknown kept by a zero delta
    settle();

    // Random phases, each under fresh register settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_map($urandom_range(1), pick_step(), pick_step(), pick_origin(GRID_X),
              pick_origin(GRID_Y), pick_origin(GRID_Z), pick_thresh());
      new_hot_cells();
      calm = (p == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == PHASE_ITEMS / 2) drain();
        random_item();
      end
      calm = 1'b0;
      settle();
    end

    drain();
    repeat (20) @(negedge clk_i);
    $display("Checked %0d results under %0d register settings: %0d on the grid, %0d clears.",
             n_checked, settings_used, n_on_grid, n_clears);
    $display("Stimulus mixed hits, misses, merges, reads and spare codes over hot cells,");
    $display("grid edges and random coordinates in both value modes.");
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: voxel_occupancy_update.f
sv/voxocc_pkg.sv
sv/voxocc_if.sv
sv/voxocc_front.sv
sv/voxocc_fifo.sv
sv/voxocc_back.sv
sv/voxel_occupancy_update.sv
verif/occupancy_checker.sv
verif/tb.sv
